/* design/linear_probe_hash_table_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the linear probe hash table
// Implication checks, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LPHT_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("lpht assertion failed");
`define LPHT_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("lpht assertion failed");
`else
`define LPHT_ASSERT_IMP(label, clk, rst_n, a, b)
`define LPHT_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

/* design/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants and types of the linear probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int LOG2_SLOTS = 10;
    localparam int KEY_WIDTH  = 32;
    localparam int HASH_WIDTH = 32;
    localparam int NUM_SLOTS  = 1 << LOG2_SLOTS;
    localparam int SLOT_W     = LOG2_SLOTS;
    localparam int COUNT_W    = LOG2_SLOTS + 1;
    localparam int SIZE_W     = 4;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;

    localparam logic [SIZE_W-1:0] SIZE_BITS_RESET = SIZE_W'(LOG2_SLOTS);

    localparam logic [OP_W-1:0] OP_FIND     = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 2'd2;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;   // handled as find

    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;

    typedef struct packed {
        logic                  valid;
        logic [HASH_WIDTH-1:0] hash;
        logic [KEY_WIDTH-1:0]  key;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  occupied_count;
    } result_t;

endpackage

/* design/lpht_if.sv */
// ----------------------------------------------------------------------------
// lpht channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpht_req_if;
    logic                                valid;
    logic                                ready;
    logic [lpht_pkg::OP_W-1:0]           operation;
    logic [lpht_pkg::HASH_WIDTH-1:0]     digest;
    logic [lpht_pkg::KEY_WIDTH-1:0]      key;
    modport source (output valid, operation, digest, key, input ready);
    modport sink   (input valid, operation, digest, key, output ready);
endinterface

interface lpht_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [lpht_pkg::STATUS_W-1:0]       status;
    logic [lpht_pkg::SLOT_W-1:0]         slot;
    logic [lpht_pkg::COUNT_W-1:0]        occupied_count;
    modport source (output valid, status, slot, occupied_count, input ready);
    modport sink   (input valid, status, slot, occupied_count, output ready);
endinterface

/* design/lpht_ram.sv */
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/lpht_engine.sv */
// ----------------------------------------------------------------------------
// lpht_engine
// Probe / insert / backward-shift remove sequencer around the slot RAM.
// ----------------------------------------------------------------------------
module lpht_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lpht_pkg::SIZE_W-1:0]         size_bits,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lpht_pkg::OP_W-1:0]           in_operation,
    input  logic [lpht_pkg::HASH_WIDTH-1:0]     in_digest,
    input  logic [lpht_pkg::KEY_WIDTH-1:0]      in_key,
    output logic                                res_valid,
    input  logic                                res_ready,
    output lpht_pkg::result_t                   res
);

    localparam int SW = lpht_pkg::SLOT_W;
    localparam int CW = lpht_pkg::COUNT_W;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_PRD   = 8'b0000_0100,
        S_PCHK  = 8'b0000_1000,
        S_RRD   = 8'b0001_0000,
        S_RCHK  = 8'b0010_0000,
        S_REND  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t                              state_reg, state_next;
    logic [lpht_pkg::OP_W-1:0]           op_reg, op_next;
    logic [lpht_pkg::HASH_WIDTH-1:0]     hash_reg, hash_next;
    logic [lpht_pkg::KEY_WIDTH-1:0]      key_reg, key_next;
    logic [SW-1:0]                       pos_reg, pos_next;   // probe slot, then hole
    logic [SW-1:0]                       j_reg, j_next;
    logic [CW-1:0]                       cnt_reg, cnt_next;
    logic [CW-1:0]                       count_reg, count_next;
    logic [SW-1:0]                       clr_reg, clr_next;
    lpht_pkg::result_t                   res_reg, res_next;

    logic [lpht_pkg::SIZE_W-1:0]         eff_bits;
    logic [SW-1:0]                       mask;
    logic [CW-1:0]                       size;
    logic                                full;
    logic                                ram_we;
    logic [SW-1:0]                       ram_waddr, ram_raddr;
    lpht_pkg::entry_t                    ram_wdata, rd;
    logic                                hit;
    logic [SW-1:0]                       home, hp1, dh, dj;

    always_comb
    begin
        eff_bits = size_bits;
        if (size_bits == '0)
        begin
            eff_bits = lpht_pkg::SIZE_W'(1);
        end
        else if (size_bits > lpht_pkg::SIZE_W'(lpht_pkg::LOG2_SLOTS))
        begin
            eff_bits = lpht_pkg::SIZE_W'(lpht_pkg::LOG2_SLOTS);
        end
    end

    assign mask = {SW{1'b1}} >> (lpht_pkg::SIZE_W'(lpht_pkg::LOG2_SLOTS) - eff_bits);
    assign size = {1'b0, mask} + CW'(1);
    // 4 * count >= 3 * size
    assign full = {count_reg, 2'b00} >= ({1'b0, size, 1'b0} + {2'b00, size});

    lpht_ram #(
        .WIDTH ($bits(lpht_pkg::entry_t)),
        .DEPTH (lpht_pkg::NUM_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd)
    );

    assign hit  = rd.valid && (rd.hash == hash_reg) && (rd.key == key_reg);
    assign home = rd.hash[SW-1:0] & mask;
    assign hp1  = (pos_reg + SW'(1)) & mask;
    assign dh   = (home - hp1) & mask;
    assign dj   = (j_reg - hp1) & mask;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        hash_next  = hash_reg;
        key_next   = key_reg;
        pos_next   = pos_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;
        count_next = count_reg;
        clr_next   = clr_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = pos_reg;
        ram_wdata  = '{valid: 1'b0, hash: hash_reg, key: key_reg};
        ram_raddr  = pos_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '{valid: 1'b0, hash: '0, key: '0};
                clr_next  = clr_reg + SW'(1);
                if (clr_reg == SW'(lpht_pkg::NUM_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_operation;
                    hash_next  = in_digest;
                    key_next   = in_key;
                    pos_next   = in_digest[SW-1:0] & mask;
                    cnt_next   = '0;
                    state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (hit)
                begin
                    res_next.slot   = pos_reg;
                    res_next.status = lpht_pkg::ST_FOUND;
                    state_next      = S_DONE;
                    if (op_reg == lpht_pkg::OP_REMOVE)
                    begin
                        res_next.status = lpht_pkg::ST_REMOVED;
                        j_next          = (pos_reg + SW'(1)) & mask;
                        cnt_next        = CW'(1);
                        state_next      = S_RRD;
                    end
                end
                else if (!rd.valid || cnt_reg == {1'b0, mask})
                begin
                    // miss: empty slot reached, or whole table walked
                    res_next.slot   = '0;
                    res_next.status = lpht_pkg::ST_NOT_FOUND;
                    state_next      = S_DONE;
                    if (op_reg == lpht_pkg::OP_INSERT)
                    begin
                        if (full || rd.valid)
                        begin
                            res_next.status = lpht_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we          = 1'b1;
                            ram_wdata.valid = 1'b1;
                            count_next      = count_reg + CW'(1);
                            res_next.status = lpht_pkg::ST_INSERTED;
                            res_next.slot   = pos_reg;
                        end
                    end
                end
                else
                begin
                    pos_next   = (pos_reg + SW'(1)) & mask;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_PRD;
                end
                res_next.occupied_count = count_next;
            end
            S_RRD:
            begin
                ram_raddr  = j_reg;
                state_next = S_RCHK;
            end
            S_RCHK:
            begin
                if (!rd.valid)
                begin
                    state_next = S_REND;
                end
                else
                begin
                    if (dh > dj)
                    begin
                        // shift entry back into the hole
                        ram_we    = 1'b1;
                        ram_wdata = rd;
                        pos_next  = j_reg;
                    end
                    if (cnt_reg == {1'b0, mask})
                    begin
                        state_next = S_REND;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + CW'(1);
                        j_next     = (j_reg + SW'(1)) & mask;
                        state_next = S_RRD;
                    end
                end
            end
            S_REND:
            begin
                ram_we    = 1'b1;
                ram_wdata = '{valid: 1'b0, hash: '0, key: '0};
                if (count_reg != '0)
                begin
                    count_next = count_reg - CW'(1);
                end
                res_next.occupied_count = count_next;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            state_next = S_CLEAR;
            clr_next   = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        hash_reg <= hash_next;
        key_reg  <= key_next;
        pos_reg  <= pos_next;
        j_reg    <= j_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

endmodule

/* design/linear_probe_hash_table.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing and backward-shift removal.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   operation, digest, key
//   rsp      out  valid/ready   status, slot, occupied_count
//   cfg      in   cfg_we        cfg_wdata (size_bits)
//
// One transaction at a time; each probed slot takes a read state and a check
// state on the single RAM read port, and a remove walks the following slots
// the same way during the backward shift, then clears the final hole.
// After reset and after every size_bits write a clearing pass over all 1024
// slots empties the table; req.ready stays low meanwhile.
// One result can wait in the output register while the next transaction
// runs; a longer rsp stall holds the engine and so req.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_assert.svh"

module linear_probe_hash_table (
    input  logic                           clk,
    input  logic                           rst_n,
    lpht_req_if.sink                       req,
    lpht_rsp_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic [lpht_pkg::SIZE_W-1:0]    cfg_wdata
);

    logic [lpht_pkg::SIZE_W-1:0] size_bits_reg;
    logic                        out_valid_reg, out_valid_next;
    lpht_pkg::result_t           out_reg;
    lpht_pkg::result_t           res;
    logic                        res_valid, res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_bits_reg <= lpht_pkg::SIZE_BITS_RESET;
        end
        else if (cfg_we)
        begin
            size_bits_reg <= cfg_wdata;
        end
    end

    lpht_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .size_bits    (size_bits_reg),
        .in_valid     (req.valid),
        .in_ready     (req.ready),
        .in_operation (req.operation),
        .in_digest    (req.digest),
        .in_key       (req.key),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    assign res_ready      = !out_valid_reg || rsp.ready;
    assign out_valid_next = (res_valid && res_ready) || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.slot           = out_reg.slot;
    assign rsp.occupied_count = out_reg.occupied_count;

    `LPHT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, req.valid && req.ready, !req.ready)
    `LPHT_ASSERT_IMP(a_miss_slot_zero, clk, rst_n, rsp.valid && (rsp.status == lpht_pkg::ST_FULL || rsp.status == lpht_pkg::ST_NOT_FOUND), rsp.slot == '0)
    `LPHT_ASSERT_IMP(a_count_bound, clk, rst_n, rsp.valid, rsp.occupied_count <= lpht_pkg::COUNT_W'(lpht_pkg::NUM_SLOTS))

endmodule
